// File: design/baasm_pkg.sv
// Package for the add/subtract/Booth multiply unit: payload types, command codes
// and the microprogram that sequences the datapath.
// No dependencies.
package baasm_pkg;

  localparam int IN_W  = 16;
  localparam int VAL_W = 32;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_SUB  = 2'd1,
    CMD_MUL  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]             cmd;
    logic signed [IN_W-1:0] operand_a;
    logic signed [IN_W-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    overflow_flag;
    logic                    zero_flag;
    logic                    sign_flag;
    logic                    carry_flag;
  } out_item_t;

  typedef logic [2:0] upc_t;

  localparam upc_t STEP_FETCH = 3'd0;
  localparam upc_t STEP_ADD   = 3'd1;
  localparam upc_t STEP_SUB   = 3'd2;
  localparam upc_t STEP_NONE  = 3'd3;
  localparam upc_t STEP_BOOTH = 3'd4;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SUB   = 2'd1,
    OP_BOOTH = 2'd2
  } alu_op_t;

  typedef enum logic [1:0] {
    RES_NONE = 2'd0,
    RES_SUM  = 2'd1,
    RES_ZERO = 2'd2,
    RES_PROD = 2'd3
  } res_t;

  typedef enum logic [1:0] {
    SQ_DISPATCH = 2'd0,
    SQ_RET      = 2'd1,
    SQ_LOOP     = 2'd2
  } seq_t;

  typedef struct packed {
    alu_op_t op;
    res_t    res;
    seq_t    seq;
    logic    load;
  } ctl_t;

  function automatic ctl_t ctl_rom(upc_t upc);
    ctl_t c;
    case (upc)
      STEP_FETCH: c = '{op: OP_ADD,   res: RES_NONE, seq: SQ_DISPATCH, load: 1'b1};
      STEP_ADD:   c = '{op: OP_ADD,   res: RES_SUM,  seq: SQ_RET,      load: 1'b0};
      STEP_SUB:   c = '{op: OP_SUB,   res: RES_SUM,  seq: SQ_RET,      load: 1'b0};
      STEP_NONE:  c = '{op: OP_ADD,   res: RES_ZERO, seq: SQ_RET,      load: 1'b0};
      STEP_BOOTH: c = '{op: OP_BOOTH, res: RES_PROD, seq: SQ_LOOP,     load: 1'b0};
      default:    c = '{op: OP_ADD,   res: RES_NONE, seq: SQ_RET,      load: 1'b0};
    endcase
    return c;
  endfunction

  function automatic upc_t dispatch(logic [1:0] cmd);
    upc_t t;
    case (cmd)
      CMD_ADD: t = STEP_ADD;
      CMD_SUB: t = STEP_SUB;
      CMD_MUL: t = STEP_BOOTH;
      default: t = STEP_NONE;
    endcase
    return t;
  endfunction

endpackage

// File: design/baasm_if.sv
// Valid/ready channel interfaces for the command and result streams.
// Depends on baasm_pkg for the payload types.
interface baasm_in_if import baasm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface baasm_out_if import baasm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/booth_alu_add_sub_mul.sv
// Add, subtract and radix-2 Booth multiply unit, run by a small microprogram.
// Depends on baasm_pkg and the channel interfaces in baasm_if.sv.
//
// One command is taken at a time. Add and subtract run a load step and one pass through
// the shared WIDTH+1 bit adder. Multiply runs a load step and WIDTH Booth add/shift
// steps on that same adder, the last of which writes the result register. A new
// command is taken in the cycle after its predecessor's result is written, while that
// result still waits to be taken; if the result register is still occupied, the final
// step holds until it drains. Operands are sign-extended or cut to WIDTH bits; the
// product is 2*WIDTH bits and value carries its low 32 bits, sign-extended if narrower.
module booth_alu_add_sub_mul import baasm_pkg::*; #(
  parameter int WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  baasm_in_if.sink     in_ch,
  baasm_out_if.source  out_ch
);

  localparam int CW = $clog2(WIDTH);
  localparam int PW = 2 * WIDTH;

  function automatic logic [WIDTH-1:0] fit(logic [IN_W-1:0] x);
    logic [WIDTH-1:0] r;
    for (int i = 0; i < WIDTH; i++) begin
      r[i] = x[(i < IN_W) ? i : IN_W - 1];
    end
    return r;
  endfunction

  upc_t             upc_r, upc_nxt;
  logic [WIDTH-1:0] a_r;
  logic [WIDTH:0]   acc_r;
  logic [WIDTH-1:0] q_r;
  logic             qm1_r;
  logic [CW-1:0]    cnt_r;
  out_item_t        out_r, res_item;
  logic             out_valid_r;

  ctl_t             ctl;
  logic             out_free, load, step, wr;
  logic [WIDTH:0]   ax, ay, sum;
  logic             cin;
  logic [WIDTH-1:0] r_sum;
  logic             c_raw, c_top;
  logic             y_top, c_out;
  logic [WIDTH:0]   acc_sh;
  logic [WIDTH-1:0] q_sh;
  logic [PW-1:0]    prod;
  logic [VAL_W-1:0] sum_val, prod_val;

  assign ctl       = ctl_rom(upc_r);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = ctl.load;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_comb begin
    ax  = '0;
    ay  = '0;
    cin = 1'b0;
    case (ctl.op)
      OP_ADD: begin
        ax = {1'b0, a_r};
        ay = {1'b0, q_r};
      end
      OP_SUB: begin
        ax  = {1'b0, a_r};
        ay  = {1'b0, ~q_r};
        cin = 1'b1;
      end
      OP_BOOTH: begin
        ax = acc_r;
        case ({q_r[0], qm1_r})
          2'b01: ay = {a_r[WIDTH-1], a_r};
          2'b10: begin
            ay  = ~{a_r[WIDTH-1], a_r};
            cin = 1'b1;
          end
          default: ay = '0;
        endcase
      end
      default: ;
    endcase
  end

  assign sum    = ax + ay + {{WIDTH{1'b0}}, cin};
  assign r_sum  = sum[WIDTH-1:0];
  assign c_raw  = sum[WIDTH];
  // top bit of the negated subtrahend
  assign y_top  = (ctl.op == OP_SUB) ? (~q_r[WIDTH-1] ^ (q_r[WIDTH-2:0] == '0))
                                     : ay[WIDTH-1];
  assign c_top  = ax[WIDTH-1] ^ y_top ^ sum[WIDTH-1];
  // subtracting zero carries nothing out
  assign c_out  = c_raw & ((ctl.op != OP_SUB) | (|q_r));
  assign acc_sh = {sum[WIDTH], sum[WIDTH:1]};
  assign q_sh   = {sum[0], q_r[WIDTH-1:1]};
  assign prod   = {acc_sh[WIDTH-1:0], q_sh};

  always_comb begin
    for (int i = 0; i < VAL_W; i++) begin
      sum_val[i]  = r_sum[(i < WIDTH) ? i : WIDTH - 1];
      prod_val[i] = prod[(i < PW) ? i : PW - 1];
    end
  end

  always_comb begin
    res_item = '0;
    case (ctl.res)
      RES_SUM: begin
        res_item.value         = sum_val;
        res_item.overflow_flag = c_top ^ c_out;
        res_item.zero_flag     = (r_sum == '0);
        res_item.sign_flag     = r_sum[WIDTH-1];
        res_item.carry_flag    = c_out;
      end
      RES_PROD: begin
        res_item.value     = prod_val;
        res_item.zero_flag = (prod == '0);
        res_item.sign_flag = prod[PW-1];
      end
      default: res_item = '0;
    endcase
  end

  always_comb begin
    upc_nxt = upc_r;
    load    = 1'b0;
    step    = 1'b0;
    wr      = 1'b0;
    case (ctl.seq)
      SQ_DISPATCH: begin
        if (in_ch.valid) begin
          load    = 1'b1;
          upc_nxt = dispatch(in_ch.data.cmd);
        end
      end
      SQ_RET: begin
        if (out_free) begin
          wr      = 1'b1;
          upc_nxt = STEP_FETCH;
        end
      end
      SQ_LOOP: begin
        if (cnt_r != '0) begin
          step = 1'b1;
        end else if (out_free) begin
          step    = 1'b1;
          wr      = 1'b1;
          upc_nxt = STEP_FETCH;
        end
      end
      default: upc_nxt = STEP_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= STEP_FETCH;
      out_valid_r <= 1'b0;
    end else begin
      upc_r <= upc_nxt;
      if (wr) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_r   <= fit(in_ch.data.operand_a);
      q_r   <= fit(in_ch.data.operand_b);
      acc_r <= '0;
      qm1_r <= 1'b0;
      cnt_r <= CW'(WIDTH - 1);
    end else if (step) begin
      acc_r <= acc_sh;
      q_r   <= q_sh;
      qm1_r <= q_r[0];
      cnt_r <= cnt_r - CW'(1);
    end
    if (wr) begin
      out_r <= res_item;
    end
  end

endmodule

// File: design/baasm_checker.sv
// Port-level checks for booth_alu_add_sub_mul, attached by the bind at the end.
// Depends on baasm_pkg for the result type.
module baasm_checker import baasm_pkg::*; #(
  parameter int WIDTH = 16
) (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken while one is in flight");

  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_flag |-> out_data.value == '0)
    else $error("zero flag set on nonzero value");

  a_sign_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (2 * WIDTH <= VAL_W) |-> out_data.value[VAL_W-1] == out_data.sign_flag)
    else $error("sign flag disagrees with value");

endmodule

bind booth_alu_add_sub_mul baasm_checker #(.WIDTH(WIDTH)) u_baasm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
